// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the bus decoder RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Same-cycle implication failed.");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Next-cycle implication failed.");

`endif

// ===== hw/rtl/mmbd_pkg.sv =====
// ---------------------------------------------------------------------------
// mmbd_pkg
// Types, constants and the address decode of the memory map bus decoder.
// ---------------------------------------------------------------------------
package mmbd_pkg;

   // Address map widths and store depths.
   localparam int ADDR_W             = 12;
   localparam int EXP_RAM_BYTES_DEF  = 1024;
   localparam int EXP_RAM_BYTES_MAX  = 1024;
   localparam int VIDEO_BYTES        = 256;
   localparam int LOCAL_BYTES        = 128;

   // External device select codes.
   localparam logic [1:0] SEL_NONE = 2'd0;
   localparam logic [1:0] SEL_ROM  = 2'd1;
   localparam logic [1:0] SEL_UART = 2'd2;
   localparam logic [1:0] SEL_IOP  = 2'd3;

   // One bus access.
   typedef struct packed {
      logic        action;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [15:0] key_matrix;
      logic [3:0]  modifier_keys;
   } req_type;

   // One decoded result.
   typedef struct packed {
      logic [7:0]  read_data;
      logic [1:0]  external_select;
      logic [10:0] external_offset;
      logic        external_is_write;
      logic [7:0]  external_data;
      logic        screen_update;
      logic [4:0]  screen_column;
      logic [2:0]  screen_row;
      logic [7:0]  screen_char;
   } rsp_type;

   // Address regions of the 12-bit map.
   typedef enum logic [2:0] {
      REG_ROM,
      REG_EXP,
      REG_LOCAL,
      REG_VIDEO,
      REG_KEY,
      REG_UART,
      REG_IOP,
      REG_NONE
   } region_type;

   // Classify an address. Expansion RAM covers only its populated part.
   function automatic region_type decode_region(logic [ADDR_W-1:0] a,
                                                logic [10:0] exp_bytes);
      region_type r;
      r = REG_NONE;
      if (!a[11]) begin
         r = REG_ROM;
      end else if (a[11:10] == 2'b10) begin
         if ({1'b0, a[9:0]} < exp_bytes) begin
            r = REG_EXP;
         end
      end else if (a[11:7] == 5'h1F) begin
         r = REG_LOCAL;
      end else if (a[11:7] == 5'h1E) begin
         r = REG_IOP;
      end else if (a[11:8] == 4'hE) begin
         r = REG_VIDEO;
      end else if (a[11:8] == 4'hC) begin
         r = REG_KEY;
      end else if (a[11:8] == 4'hD) begin
         r = REG_UART;
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/mmbd_ram.sv =====
// ---------------------------------------------------------------------------
// mmbd_ram
// Simple dual-port synchronous RAM with a registered read port.
// ---------------------------------------------------------------------------
module mmbd_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/mmbd_keyscan.sv =====
// ---------------------------------------------------------------------------
// mmbd_keyscan
// Keyboard matrix scan: address bits pick rows, pressed columns and the
// modifier keys form the returned byte.
// ---------------------------------------------------------------------------
module mmbd_keyscan (
   input  logic [3:0]  row_select,
   input  logic [15:0] key_matrix,
   input  logic [3:0]  modifier_keys,
   output logic [7:0]  scan_data
);

   logic [3:0] col_hit;

   // Row r is selected by address bit (3 - r); column c lands in bit (3 - c).
   always_comb begin
      col_hit = '0;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            if (row_select[3 - r] && key_matrix[c + 4 * r]) begin
               col_hit[3 - c] = 1'b1;
            end
         end
      end
   end

   assign scan_data = {modifier_keys, col_hit};

endmodule

// ===== hw/rtl/memory_map_bus_decoder.sv =====
// ---------------------------------------------------------------------------
// memory_map_bus_decoder
// Decodes bus accesses over a 12-bit map with internal RAM, video store
// and keyboard, and forwards ROM reads and UART and I/O-port accesses.
// ---------------------------------------------------------------------------
// Usage:
//   An item is taken at a rising edge with start high and busy low. Its
//   address is presented to the store RAMs at that edge; in the next cycle
//   (busy high) the read data returns, the result is formed and any store
//   write-back happens at the closing edge. The result then sits on rsp_item
//   for one cycle with rsp_strobe high.
//   No new item is taken while busy is high, as the read-then-write-back
//   pass through the store RAMs must finish first.
//   Video store writes compare against the stored byte and strobe a screen
//   update only when it changes; the receiver cannot stall, so every result
//   is taken in its strobe cycle.
//   The csr channel writes the screen inversion bit and is always ready;
//   write it only while the block is idle, which the block does not check.
//   Reset clears the control state, the inversion bit and the video store
//   valid bits, so the video store reads as zero at once; there is no
//   clearing pass. Expansion and local RAM are undefined until written.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module memory_map_bus_decoder #(
   parameter int EXP_RAM_BYTES = mmbd_pkg::EXP_RAM_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mmbd_pkg::req_type req_item,
   output logic             rsp_strobe,
   output mmbd_pkg::rsp_type rsp_item,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_write_data
);

   localparam int EXP_AW = (EXP_RAM_BYTES > 1) ? $clog2(EXP_RAM_BYTES) : 1;
   localparam int VID_AW = $clog2(mmbd_pkg::VIDEO_BYTES);
   localparam int LOC_AW = $clog2(mmbd_pkg::LOCAL_BYTES);
   localparam logic [10:0] EXP_BYTES_W = 11'(EXP_RAM_BYTES);

   logic                    accept;
   logic                    stage_valid_ff;
   logic                    stage_valid_in;
   mmbd_pkg::req_type       req_ff;
   mmbd_pkg::rsp_type       rsp_ff;
   mmbd_pkg::rsp_type       rsp_in;
   logic                    rsp_strobe_ff;
   logic                    inverted_ff;
   logic [mmbd_pkg::VIDEO_BYTES-1:0] vid_valid_ff;
   logic                    vid_hit_ff;

   logic [mmbd_pkg::ADDR_W-1:0] addr;
   mmbd_pkg::region_type    region;
   logic                    is_write;
   logic [7:0]              exp_rd;
   logic [7:0]              loc_rd;
   logic [7:0]              vid_rd;
   logic [7:0]              vid_old;
   logic [7:0]              key_rd;
   logic                    exp_we;
   logic                    loc_we;
   logic                    vid_we;

   assign accept    = start && !busy;
   assign busy      = stage_valid_ff;
   assign csr_ready = 1'b1;

   // Accept an item and hold it for the read-modify-write cycle.
   assign stage_valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_strobe_ff  <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_item;
      end
      if (stage_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   // Screen inversion register.
   always_ff @(posedge clock) begin
      if (reset) begin
         inverted_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         inverted_ff <= csr_write_data;
      end
   end

   // Decode of the item in flight.
   assign addr     = req_ff.address[mmbd_pkg::ADDR_W-1:0];
   assign region   = mmbd_pkg::decode_region(addr, EXP_BYTES_W);
   assign is_write = req_ff.action;

   assign exp_we = stage_valid_ff && is_write && (region == mmbd_pkg::REG_EXP);
   assign loc_we = stage_valid_ff && is_write && (region == mmbd_pkg::REG_LOCAL);
   assign vid_we = stage_valid_ff && is_write && (region == mmbd_pkg::REG_VIDEO);

   // Store RAMs: read at acceptance, write back at the end of the busy cycle.
   mmbd_ram #(
      .DEPTH (EXP_RAM_BYTES),
      .WIDTH (8)
   ) u_exp_ram (
      .clock   (clock),
      .wr_en   (exp_we),
      .wr_addr (addr[EXP_AW-1:0]),
      .wr_data (req_ff.write_data),
      .rd_en   (accept),
      .rd_addr (req_item.address[EXP_AW-1:0]),
      .rd_data (exp_rd)
   );

   mmbd_ram #(
      .DEPTH (mmbd_pkg::LOCAL_BYTES),
      .WIDTH (8)
   ) u_loc_ram (
      .clock   (clock),
      .wr_en   (loc_we),
      .wr_addr (addr[LOC_AW-1:0]),
      .wr_data (req_ff.write_data),
      .rd_en   (accept),
      .rd_addr (req_item.address[LOC_AW-1:0]),
      .rd_data (loc_rd)
   );

   mmbd_ram #(
      .DEPTH (mmbd_pkg::VIDEO_BYTES),
      .WIDTH (8)
   ) u_vid_ram (
      .clock   (clock),
      .wr_en   (vid_we),
      .wr_addr (addr[VID_AW-1:0]),
      .wr_data (req_ff.write_data),
      .rd_en   (accept),
      .rd_addr (req_item.address[VID_AW-1:0]),
      .rd_data (vid_rd)
   );

   // Video valid bits: an entry never written since reset reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         vid_valid_ff <= '0;
      end else if (vid_we) begin
         vid_valid_ff[addr[VID_AW-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         vid_hit_ff <= vid_valid_ff[req_item.address[VID_AW-1:0]];
      end
   end

   assign vid_old = vid_hit_ff ? vid_rd : 8'h00;

   // Keyboard scan of the item in flight.
   mmbd_keyscan u_keyscan (
      .row_select    (addr[3:0]),
      .key_matrix    (req_ff.key_matrix),
      .modifier_keys (req_ff.modifier_keys),
      .scan_data     (key_rd)
   );

   // Result formation per region.
   always_comb begin
      rsp_in = '0;
      unique case (region)
         mmbd_pkg::REG_ROM: begin
            if (!is_write) begin
               rsp_in.external_select = mmbd_pkg::SEL_ROM;
               rsp_in.external_offset = addr[10:0];
            end
         end
         mmbd_pkg::REG_EXP: begin
            if (!is_write) begin
               rsp_in.read_data = exp_rd;
            end
         end
         mmbd_pkg::REG_LOCAL: begin
            if (!is_write) begin
               rsp_in.read_data = loc_rd;
            end
         end
         mmbd_pkg::REG_VIDEO: begin
            if (!is_write) begin
               rsp_in.read_data = vid_old;
            end else if (vid_old != req_ff.write_data) begin
               rsp_in.screen_update = 1'b1;
               rsp_in.screen_column = addr[4:0];
               rsp_in.screen_row    = addr[7:5];
               rsp_in.screen_char   = req_ff.write_data ^ {inverted_ff, 7'b0};
            end
         end
         mmbd_pkg::REG_KEY: begin
            if (!is_write) begin
               rsp_in.read_data = key_rd;
            end
         end
         mmbd_pkg::REG_UART: begin
            rsp_in.external_select   = mmbd_pkg::SEL_UART;
            rsp_in.external_offset   = {3'b000, addr[7:0]};
            rsp_in.external_is_write = is_write;
            rsp_in.external_data     = is_write ? req_ff.write_data : 8'h00;
         end
         mmbd_pkg::REG_IOP: begin
            rsp_in.external_select   = mmbd_pkg::SEL_IOP;
            rsp_in.external_offset   = {4'b0000, addr[6:0]};
            rsp_in.external_is_write = is_write;
            rsp_in.external_data     = is_write ? req_ff.write_data : 8'h00;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // Checks on sequencing and result encoding.
   `ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy)
   `ASSERT_NEXT(a_busy_strobe, clock, reset, busy, rsp_strobe && !busy)
   `ASSERT_IMPLIES(a_strobe_idle, clock, reset, rsp_strobe, !busy)
   `ASSERT_IMPLIES(a_no_update_clear, clock, reset,
                   rsp_strobe && !rsp_item.screen_update,
                   rsp_item.screen_column == 5'd0 && rsp_item.screen_row == 3'd0
                   && rsp_item.screen_char == 8'd0)
   `ASSERT_IMPLIES(a_no_ext_clear, clock, reset,
                   rsp_strobe && rsp_item.external_select == mmbd_pkg::SEL_NONE,
                   rsp_item.external_offset == 11'd0 && !rsp_item.external_is_write)

endmodule

// ===== tb/bus_decode_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// bus_decode_checker
// Watches the access, result and csr channels of the bus decoder. Each
// accepted access is decoded here against a private copy of the stores and
// the inversion bit, and every strobed result is compared field by field
// with the oldest decoded access still waiting.
// ---------------------------------------------------------------------------
module bus_decode_checker import mmbd_pkg::*; #(
   parameter int EXP_BYTES = EXP_RAM_BYTES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_item,
   input  logic    rsp_strobe,
   input  rsp_type rsp_item,
   input  logic    csr_valid,
   input  logic    csr_ready,
   input  logic    csr_write_data,
   input  logic    end_check,
   output int      error_count,
   output int      result_count
);

   // Private copy of the block's stores and its inversion bit.
   logic [7:0] exp_mem   [0:EXP_RAM_BYTES_MAX-1];
   logic [7:0] video_mem [0:VIDEO_BYTES-1];
   logic [7:0] local_mem [0:LOCAL_BYTES-1];
   logic       invert_bit;

   // Decoded results still waiting for their item on the result channel.
   rsp_type decoded_q [$];
   rsp_type want;
   bit      end_checked;

   initial begin
      error_count  = 0;
      result_count = 0;
      invert_bit   = 1'b0;
      end_checked  = 1'b0;
      for (int i = 0; i < VIDEO_BYTES; i++) begin
         video_mem[i] = 8'h00;
      end
   end

   // Print one line per problem, up to a cap, and count every one.
   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= 40) begin
         $display("ERROR at %0t ns: %s", $time, msg);
      end
   endtask

   // Keyboard scan: each row enabled by an address bit ORs its pressed
   // columns into the low nibble; the modifiers fill the high nibble.
   function automatic logic [7:0] scan_keyboard(logic [3:0] row_sel, logic [15:0] keys,
                                                logic [3:0] mods);
      logic [7:0] v;
      v = {mods, 4'h0};
      for (int r = 0; r < 4; r++) begin
         if (row_sel[3-r]) begin
            for (int c = 0; c < 4; c++) begin
               if (keys[c + 4*r]) begin
                  v[3-c] = 1'b1;
               end
            end
         end
      end
      return v;
   endfunction

   // Decode one access and apply its side effects to the store copies.
   function automatic rsp_type decode_access(req_type acc);
      rsp_type     r;
      logic [11:0] a;
      logic [3:0]  page;
      r    = '0;
      a    = acc.address[11:0];
      page = a[11:8];
      if (!acc.action) begin
         if (a < 12'h800) begin
            r.external_select = SEL_ROM;
            r.external_offset = a[10:0];
         end else if (int'(a) < 32'h800 + EXP_BYTES) begin
            r.read_data = exp_mem[a[9:0]];
         end else if (a >= 12'hF80) begin
            r.read_data = local_mem[a[6:0]];
         end else if (page == 4'hE) begin
            r.read_data = video_mem[a[7:0]];
         end else if (page == 4'hC) begin
            r.read_data = scan_keyboard(a[3:0], acc.key_matrix, acc.modifier_keys);
         end else if (page == 4'hD) begin
            r.external_select = SEL_UART;
            r.external_offset = {3'b000, a[7:0]};
         end else if (a[11:7] == 5'h1E) begin
            r.external_select = SEL_IOP;
            r.external_offset = {4'h0, a[6:0]};
         end
      end else begin
         if (a >= 12'hF80) begin
            local_mem[a[6:0]] = acc.write_data;
         end else if (a[11:10] == 2'b10) begin
            if (int'(a[9:0]) < EXP_BYTES) begin
               exp_mem[a[9:0]] = acc.write_data;
            end
         end else if (page == 4'hE) begin
            // Only a changed byte asks for a redraw of its cell.
            if (video_mem[a[7:0]] != acc.write_data) begin
               video_mem[a[7:0]] = acc.write_data;
               r.screen_update   = 1'b1;
               r.screen_column   = a[4:0];
               r.screen_row      = a[7:5];
               r.screen_char     = acc.write_data ^ {invert_bit, 7'b0};
            end
         end else if (page == 4'hD) begin
            r.external_select   = SEL_UART;
            r.external_offset   = {3'b000, a[7:0]};
            r.external_is_write = 1'b1;
            r.external_data     = acc.write_data;
         end else if (a[11:7] == 5'h1E) begin
            r.external_select   = SEL_IOP;
            r.external_offset   = {4'h0, a[6:0]};
            r.external_is_write = 1'b1;
            r.external_data     = acc.write_data;
         end
      end
      return r;
   endfunction

   // Compare strobed results first, then decode the item taken at this edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            result_count <= result_count + 1;
            if (decoded_q.size() == 0) begin
               report_error("result item strobed with no access waiting");
            end else begin
               want = decoded_q.pop_front();
               if (rsp_item.read_data !== want.read_data)
                  report_error($sformatf("read_data got %h want %h",
                                         rsp_item.read_data, want.read_data));
               if (rsp_item.external_select !== want.external_select)
                  report_error($sformatf("external_select got %h want %h",
                                         rsp_item.external_select, want.external_select));
               if (rsp_item.external_offset !== want.external_offset)
                  report_error($sformatf("external_offset got %h want %h",
                                         rsp_item.external_offset, want.external_offset));
               if (rsp_item.external_is_write !== want.external_is_write)
                  report_error($sformatf("external_is_write got %b want %b",
                                         rsp_item.external_is_write, want.external_is_write));
               if (rsp_item.external_data !== want.external_data)
                  report_error($sformatf("external_data got %h want %h",
                                         rsp_item.external_data, want.external_data));
               if (rsp_item.screen_update !== want.screen_update)
                  report_error($sformatf("screen_update got %b want %b",
                                         rsp_item.screen_update, want.screen_update));
               if (rsp_item.screen_column !== want.screen_column)
                  report_error($sformatf("screen_column got %h want %h",
                                         rsp_item.screen_column, want.screen_column));
               if (rsp_item.screen_row !== want.screen_row)
                  report_error($sformatf("screen_row got %h want %h",
                                         rsp_item.screen_row, want.screen_row));
               if (rsp_item.screen_char !== want.screen_char)
                  report_error($sformatf("screen_char got %h want %h",
                                         rsp_item.screen_char, want.screen_char));
            end
         end
         if (start && !busy) begin
            decoded_q.push_back(decode_access(req_item));
         end
         if (csr_valid && csr_ready) begin
            invert_bit = csr_write_data;
         end
         // Anything still queued at the end never got its result.
         if (end_check && !end_checked) begin
            end_checked = 1'b1;
            if (decoded_q.size() != 0) begin
               report_error($sformatf("%0d accesses never produced a result",
                                      decoded_q.size()));
            end
         end
      end
   end

endmodule

// ===== tb/memory_map_bus_decoder_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// memory_map_bus_decoder_tb
// Drives bus accesses into the decoder: a directed pass over every region
// and its corner cases, then random phases under both inversion settings,
// all but one with random gaps between items. The checker beside the block
// predicts and compares every result; this module only stimulates and judges.
// ---------------------------------------------------------------------------
module memory_map_bus_decoder_tb;
   import mmbd_pkg::*;

   localparam logic ACT_READ  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;
   localparam int   CYCLE_LIMIT = 200000;
   localparam int   PHASES      = 6;
   localparam int   PHASE_ITEMS = 225;

   // Random mix of access kinds; the hot video kind hits eight cells with
   // four data values so that unchanged writes come up often.
   typedef enum int {
      MIX_ROM_READ,
      MIX_ROM_WRITE,
      MIX_EXP_WRITE,
      MIX_EXP_READ,
      MIX_LOCAL_WRITE,
      MIX_LOCAL_READ,
      MIX_VIDEO_WRITE,
      MIX_VIDEO_HOT,
      MIX_VIDEO_READ,
      MIX_KEY_READ,
      MIX_KEY_WRITE,
      MIX_UART,
      MIX_IOP,
      MIX_COUNT
   } mix_kind_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;
   logic    csr_valid;
   logic    csr_ready;
   logic    csr_write_data;
   logic    end_check;
   int      error_count;
   int      result_count;
   int      issued;
   int      cycle_count;
   bit      allow_gaps;

   // Written entries of the RAMs that have no reset value; reads only go
   // to these.
   bit          exp_written   [0:EXP_RAM_BYTES_MAX-1];
   bit          local_written [0:LOCAL_BYTES-1];
   int unsigned exp_list   [$];
   int unsigned local_list [$];

   memory_map_bus_decoder dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_item       (req_item),
      .rsp_strobe     (rsp_strobe),
      .rsp_item       (rsp_item),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_write_data (csr_write_data)
   );

   bus_decode_checker decode_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_item       (req_item),
      .rsp_strobe     (rsp_strobe),
      .rsp_item       (rsp_item),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_write_data (csr_write_data),
      .end_check      (end_check),
      .error_count    (error_count),
      .result_count   (result_count)
   );

   always #10 clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Build one access and note which RAM entries it writes.
   function automatic req_type make_access(logic wr, logic [15:0] addr, logic [7:0] data,
                                           logic [15:0] keys, logic [3:0] mods);
      req_type acc;
      acc.action        = wr;
      acc.address       = addr;
      acc.write_data    = data;
      acc.key_matrix    = keys;
      acc.modifier_keys = mods;
      if (wr == ACT_WRITE) begin
         if (addr[11:7] == 5'h1F) begin
            if (!local_written[addr[6:0]]) begin
               local_written[addr[6:0]] = 1'b1;
               local_list.push_back(32'(addr[6:0]));
            end
         end else if (addr[11:10] == 2'b10) begin
            if (!exp_written[addr[9:0]]) begin
               exp_written[addr[9:0]] = 1'b1;
               exp_list.push_back(32'(addr[9:0]));
            end
         end
      end
      return acc;
   endfunction

   // Random access with random don't-care bits, steered into one region.
   function automatic req_type random_access();
      logic [3:0]   hi;
      logic [11:0]  a;
      logic [7:0]   data;
      logic [15:0]  keys;
      logic [3:0]   mods;
      logic         wr;
      mix_kind_type kind;
      hi   = 4'($urandom);
      a    = 12'($urandom);
      data = 8'($urandom);
      keys = 16'($urandom);
      mods = 4'($urandom);
      wr   = 1'($urandom);
      kind = mix_kind_type'($urandom_range(0, MIX_COUNT - 1));
      // Reads of RAM need something written first.
      if (kind == MIX_EXP_READ && exp_list.size() == 0) begin
         kind = MIX_EXP_WRITE;
      end
      if (kind == MIX_LOCAL_READ && local_list.size() == 0) begin
         kind = MIX_LOCAL_WRITE;
      end
      case (kind)
         MIX_ROM_READ: begin
            wr = ACT_READ;
            a  = {1'b0, a[10:0]};
         end
         MIX_ROM_WRITE: begin
            wr = ACT_WRITE;
            a  = {1'b0, a[10:0]};
         end
         MIX_EXP_WRITE: begin
            wr = ACT_WRITE;
            a  = {2'b10, a[9:0]};
         end
         MIX_EXP_READ: begin
            wr = ACT_READ;
            a  = 12'h800 + 12'(exp_list[$urandom_range(0, exp_list.size() - 1)]);
         end
         MIX_LOCAL_WRITE: begin
            wr = ACT_WRITE;
            a  = {5'h1F, a[6:0]};
         end
         MIX_LOCAL_READ: begin
            wr = ACT_READ;
            a  = 12'hF80 + 12'(local_list[$urandom_range(0, local_list.size() - 1)]);
         end
         MIX_VIDEO_WRITE: begin
            wr = ACT_WRITE;
            a  = {4'hE, a[7:0]};
         end
         MIX_VIDEO_HOT: begin
            wr   = ACT_WRITE;
            a    = {9'h1C0, a[2:0]};
            data = {7'b0, data[0]} ^ {data[1], 7'b0};
         end
         MIX_VIDEO_READ: begin
            wr = ACT_READ;
            a  = {4'hE, a[7:0]};
         end
         MIX_KEY_READ: begin
            wr = ACT_READ;
            a  = {4'hC, a[7:0]};
         end
         MIX_KEY_WRITE: begin
            wr = ACT_WRITE;
            a  = {4'hC, a[7:0]};
         end
         MIX_UART: begin
            a = {4'hD, a[7:0]};
         end
         default: begin
            a = {5'h1E, a[6:0]};
         end
      endcase
      return make_access(wr, {hi, a}, data, keys, mods);
   endfunction

   // Offer one item and wait for it to be taken, then maybe idle.
   task automatic send_access(input req_type acc);
      int gap;
      req_item <= acc;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      issued++;
      gap = allow_gaps ? int'($urandom_range(0, 3)) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering items and wait until every result has come back.
   task automatic drain_results();
      start <= 1'b0;
      while (result_count != issued) @(posedge clock);
   endtask

   // Write the screen inversion bit while the block is idle.
   task automatic write_invert(input logic value);
      csr_write_data <= value;
      csr_valid      <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_item       = '0;
      csr_valid      = 1'b0;
      csr_write_data = 1'b0;
      end_check      = 1'b0;
      issued         = 0;
      cycle_count    = 0;
      allow_gaps     = 1'b1;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_invert(1'b0);

      // Directed pass: region edges, ignored writes, unchanged video
      // writes and the keyboard scan with all, none and some keys.
      send_access(make_access(ACT_READ,  16'h0000, 8'h00, 16'h0000, 4'h0));
      send_access(make_access(ACT_READ,  16'hF7FF, 8'hFF, 16'hFFFF, 4'hF));
      send_access(make_access(ACT_WRITE, 16'h0123, 8'hFF, 16'h0000, 4'h0));
      send_access(make_access(ACT_WRITE, 16'h0800, 8'h00, 16'h0000, 4'h0));
      send_access(make_access(ACT_WRITE, 16'hFBFF, 8'hFF, 16'h0000, 4'h0));
      send_access(make_access(ACT_READ,  16'h0800, 8'h00, 16'h0000, 4'h0));
      send_access(make_access(ACT_READ,  16'h0BFF, 8'h00, 16'h0000, 4'h0));
      send_access(make_access(ACT_WRITE, 16'h0F80, 8'hA5, 16'h0000, 4'h0));
      send_access(make_access(ACT_WRITE, 16'hFFFF, 8'h5A, 16'h0000, 4'h0));
      send_access(make_access(ACT_READ,  16'h0F80, 8'h00, 16'h0000, 4'h0));
      send_access(make_access(ACT_READ,  16'hAFFF, 8'h00, 16'h0000, 4'h0));
      send_access(make_access(ACT_READ,  16'h0E80, 8'h00, 16'h0000, 4'h0));
      send_access(make_access(ACT_WRITE, 16'h0E00, 8'h5A, 16'h0000, 4'h0));
      send_access(make_access(ACT_WRITE, 16'h0E00, 8'h5A, 16'h0000, 4'h0));
      send_access(make_access(ACT_WRITE, 16'h0EFF, 8'hFF, 16'h0000, 4'h0));
      send_access(make_access(ACT_WRITE, 16'h0E01, 8'h00, 16'h0000, 4'h0));
      send_access(make_access(ACT_READ,  16'h0E00, 8'h00, 16'h0000, 4'h0));
      send_access(make_access(ACT_READ,  16'h0C0F, 8'h00, 16'hFFFF, 4'hF));
      send_access(make_access(ACT_READ,  16'h0C00, 8'h00, 16'hFFFF, 4'h0));
      send_access(make_access(ACT_READ,  16'h0C05, 8'h00, 16'h8421, 4'hA));
      send_access(make_access(ACT_WRITE, 16'h0CFF, 8'h3C, 16'hFFFF, 4'hF));
      send_access(make_access(ACT_READ,  16'h0D00, 8'h00, 16'h0000, 4'h0));
      send_access(make_access(ACT_WRITE, 16'h0DFF, 8'hA5, 16'h0000, 4'h0));
      send_access(make_access(ACT_READ,  16'h0F00, 8'h00, 16'h0000, 4'h0));
      send_access(make_access(ACT_WRITE, 16'h0F7F, 8'hFF, 16'h0000, 4'h0));

      // Random phases; inversion changes only with the block idle, and one
      // phase runs without gaps.
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         if (phase == PHASES - 1) begin
            write_invert(1'($urandom_range(0, 1)));
         end else begin
            write_invert(phase[0] ? 1'b0 : 1'b1);
         end
         allow_gaps = (phase != 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 2 && n == PHASE_ITEMS / 2) begin
               drain_results();
            end
            send_access(random_access());
         end
      end

      // Let the last results arrive, then look for leftovers.
      drain_results();
      repeat (4) @(posedge clock);
      end_check <= 1'b1;
      repeat (3) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mmbd_pkg.sv
hw/rtl/mmbd_ram.sv
hw/rtl/mmbd_keyscan.sv
hw/rtl/memory_map_bus_decoder.sv
tb/bus_decode_checker.sv
tb/memory_map_bus_decoder_tb.sv
